/* rtl/hrdv_pkg.sv */
// Shared constants, types and fixed-point helpers for the heading-relative drive vector.
package hrdv_pkg;

  localparam int ENCODER_COUNTS = 8192;
  localparam int ENC_BITS = $clog2(ENCODER_COUNTS);
  // One encoder count is 2^PHASE_SHIFT units of 2^-32 turn.
  localparam int PHASE_SHIFT = 32 - ENC_BITS;

  // Unsigned Q30 values up to and including 1.0
  localparam int QW = 31;
  typedef logic [QW-1:0] q30_t;

  localparam q30_t        Q30_ONE  = q30_t'(64'd1 << 30);
  localparam logic [62:0] Q30_HALF = 63'(64'd1 << 29);
  localparam logic [31:0] PI_Q30   = 32'd3373259426;

  // Reciprocals for floor(x / d) with x < 2^31: m = ceil(2^s / d), s = 31 + ceil(log2 d)
  localparam int SH_72 = 38;
  localparam int SH_42 = 37;
  localparam int SH_20 = 36;
  localparam int SH_6  = 34;
  localparam int SH_90 = 38;
  localparam int SH_56 = 37;
  localparam int SH_30 = 36;
  localparam int SH_12 = 35;
  localparam logic [31:0] RCP_72 = 32'(((64'd1 << SH_72) + 64'd71) / 64'd72);
  localparam logic [31:0] RCP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [31:0] RCP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [31:0] RCP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [31:0] RCP_90 = 32'(((64'd1 << SH_90) + 64'd89) / 64'd90);
  localparam logic [31:0] RCP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [31:0] RCP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [31:0] RCP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  // Register stages inside the sine/cosine unit
  localparam int SC_LAT = 11;

  typedef enum logic [1:0] {
    CFG_DEAD_ZONE   = 2'd0,
    CFG_YAW_NEUTRAL = 2'd1,
    CFG_SPIN_MOVING = 2'd2,
    CFG_SPIN_IDLE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic adv;  // pipeline moves this cycle
    logic vld;  // a transaction enters this cycle
  } pipe_ctl_t;

  // Q30 product, rounded half up
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic [62:0] p;
    p = 63'(a) * 63'(b) + Q30_HALF;
    return p[60:30];
  endfunction

  // Truncating divide by a small constant through its reciprocal
  function automatic q30_t rdiv(input q30_t x, input logic [31:0] m, input int s);
    logic [62:0] p;
    p = 63'(x) * 63'(m);
    return q30_t'(p >> s);
  endfunction

endpackage

/* rtl/hrdv_sincos.sv */
// Pipelined sine/cosine of an encoder angle by Taylor polynomials in Q30.
module hrdv_sincos
  import hrdv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pipe_ctl_t           pipe_i,
  input  logic [ENC_BITS-1:0] delta_i,
  output logic                vld_o,
  output logic signed [31:0]  sin_o,
  output logic signed [31:0]  cos_o
);

  typedef struct packed {
    q30_t       t;
    q30_t       t2;
    logic [1:0] quad;
    logic       neg;
    q30_t       sa;   // sine Horner accumulator
    q30_t       ca;   // cosine Horner accumulator
  } trig_t;

  trig_t st_d [1:SC_LAT-1];
  trig_t st_q [1:SC_LAT-1];
  logic  vld_q [1:SC_LAT];

  logic [31:0]       phase;
  logic [29:0]       mag;
  logic [61:0]       tprod;
  q30_t              c_fin;
  logic signed [31:0] s_sgn;
  logic signed [31:0] c_sgn;
  logic signed [31:0] sin_d;
  logic signed [31:0] cos_d;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;

  always_comb begin
    // Split the phase into the nearest quarter turn and a signed residual
    phase = 32'(delta_i) << PHASE_SHIFT;
    if (phase[29]) begin
      mag = 30'(31'(Q30_ONE) - 31'(phase[29:0]));
    end else begin
      mag = phase[29:0];
    end
    tprod = 62'(mag) * 62'(PI_Q30);

    st_d[1]      = '0;
    st_d[1].t    = q30_t'(tprod >> 31);
    st_d[1].quad = phase[31:30] + 2'(phase[29]);
    st_d[1].neg  = phase[29];

    st_d[2]    = st_q[1];
    st_d[2].t2 = qmul(st_q[1].t, st_q[1].t);

    st_d[3]    = st_q[2];
    st_d[3].sa = Q30_ONE - rdiv(st_q[2].t2, RCP_72, SH_72);
    st_d[3].ca = Q30_ONE - rdiv(st_q[2].t2, RCP_90, SH_90);

    st_d[4]    = st_q[3];
    st_d[4].sa = qmul(st_q[3].t2, st_q[3].sa);
    st_d[4].ca = qmul(st_q[3].t2, st_q[3].ca);

    st_d[5]    = st_q[4];
    st_d[5].sa = Q30_ONE - rdiv(st_q[4].sa, RCP_42, SH_42);
    st_d[5].ca = Q30_ONE - rdiv(st_q[4].ca, RCP_56, SH_56);

    st_d[6]    = st_q[5];
    st_d[6].sa = qmul(st_q[5].t2, st_q[5].sa);
    st_d[6].ca = qmul(st_q[5].t2, st_q[5].ca);

    st_d[7]    = st_q[6];
    st_d[7].sa = Q30_ONE - rdiv(st_q[6].sa, RCP_20, SH_20);
    st_d[7].ca = Q30_ONE - rdiv(st_q[6].ca, RCP_30, SH_30);

    st_d[8]    = st_q[7];
    st_d[8].sa = qmul(st_q[7].t2, st_q[7].sa);
    st_d[8].ca = qmul(st_q[7].t2, st_q[7].ca);

    st_d[9]    = st_q[8];
    st_d[9].sa = Q30_ONE - rdiv(st_q[8].sa, RCP_6, SH_6);
    st_d[9].ca = Q30_ONE - rdiv(st_q[8].ca, RCP_12, SH_12);

    // Sine closes with a product by t, cosine with a product by t^2
    st_d[10]    = st_q[9];
    st_d[10].sa = qmul(st_q[9].t, st_q[9].sa);
    st_d[10].ca = qmul(st_q[9].t2, st_q[9].ca);

    // Apply the quarter turn exactly
    c_fin = Q30_ONE - (st_q[10].ca >> 1);
    c_sgn = signed'(32'(c_fin));
    s_sgn = st_q[10].neg ? -signed'(32'(st_q[10].sa)) : signed'(32'(st_q[10].sa));
    case (st_q[10].quad)
      2'd0: begin
        cos_d = c_sgn;
        sin_d = s_sgn;
      end
      2'd1: begin
        cos_d = -s_sgn;
        sin_d = c_sgn;
      end
      2'd2: begin
        cos_d = -c_sgn;
        sin_d = -s_sgn;
      end
      default: begin
        cos_d = s_sgn;
        sin_d = -c_sgn;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= SC_LAT; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (pipe_i.adv) begin
      vld_q[1] <= pipe_i.vld;
      for (int k = 2; k <= SC_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.adv) begin
      for (int k = 1; k < SC_LAT; k++) begin
        st_q[k] <= st_d[k];
      end
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign vld_o = vld_q[SC_LAT];
  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

/* rtl/heading_relative_drive_vector.sv */
// Top level: joystick vector rotation into the chassis frame with dead zone and spin select.
//
// Rotates the stick vector by the turret angle (yaw_encoder - yaw_neutral) and
// returns the rotated drive vector plus a spin command picked by whether the
// stick is outside the dead zone; outputs below the dead zone read as zero.
// One transaction is taken per clock while in_stall_o is low. Its result passes
// through the sine/cosine evaluation: the angle scaling and nine dependent Q30
// products and reciprocal divides, one multiplier stage each, then the
// quarter-turn select, followed by the rotation products, rounding and the
// output register. A two-entry output buffer lets the input keep flowing while
// one result waits downstream; the input stalls only when both entries are
// full. Configuration is taken on any cycle with cfg_we_i high.
module heading_relative_drive_vector
  import hrdv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  logic [12:0]        yaw_encoder_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_x_o,
  output logic signed [15:0] drive_y_o,
  output logic signed [15:0] spin_rate_o
);

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] sp;
  } res_t;

  logic [14:0]        dead_zone_q;
  logic [12:0]        yaw_neutral_q;
  logic signed [15:0] spin_moving_q;
  logic signed [15:0] spin_idle_q;

  pipe_ctl_t           pipe;
  logic [ENC_BITS-1:0] delta;
  logic                sc_vld;
  logic signed [31:0]  sc_sin;
  logic signed [31:0]  sc_cos;

  logic signed [15:0] xd_q [1:SC_LAT];
  logic signed [15:0] yd_q [1:SC_LAT];

  logic               v12_q;
  logic signed [48:0] sx_d, sy_d, sx_q, sy_q;
  logic signed [32:0] sq_d;
  logic [31:0]        sq_q;

  logic               v13_q;
  logic [29:0]        dz_sq;
  res_t               r13_d, r13_q;
  res_t               res;

  logic out_valid_q, skid_valid_q, out_take;
  res_t out_q, skid_q;

  function automatic logic signed [15:0] round_sat(input logic signed [48:0] v);
    logic [48:0] m;
    logic [48:0] q;
    m = v[48] ? 49'(-v) : 49'(v);
    q = (m + 49'(Q30_HALF)) >> 30;
    if (v[48]) begin
      return (q >= 49'd32768) ? 16'sh8000 : signed'(16'd0 - q[15:0]);
    end
    return (q >= 49'd32767) ? 16'sh7fff : signed'(q[15:0]);
  endfunction

  // Drop a value whose magnitude is below the dead zone
  function automatic logic signed [15:0] dz_keep(input logic signed [15:0] v,
                                                  input logic [14:0] dz);
    logic [16:0] a;
    a = v[15] ? 17'(17'sd0 - 17'(v)) : 17'(v);
    return (a < 17'(dz)) ? 16'sd0 : v;
  endfunction

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q   <= '0;
      yaw_neutral_q <= '0;
      spin_moving_q <= '0;
      spin_idle_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEAD_ZONE:   dead_zone_q   <= cfg_wdata_i[14:0];
        CFG_YAW_NEUTRAL: yaw_neutral_q <= cfg_wdata_i[12:0];
        CFG_SPIN_MOVING: spin_moving_q <= signed'(cfg_wdata_i);
        CFG_SPIN_IDLE:   spin_idle_q   <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // The whole pipeline holds only while the output buffer is full
  assign in_stall_o = skid_valid_q;
  assign pipe.adv   = !skid_valid_q;
  assign pipe.vld   = in_valid_i && !skid_valid_q;
  assign delta      = ENC_BITS'(yaw_encoder_i) - ENC_BITS'(yaw_neutral_q);

  hrdv_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pipe_i  (pipe),
    .delta_i (delta),
    .vld_o   (sc_vld),
    .sin_o   (sc_sin),
    .cos_o   (sc_cos)
  );

  // Stick components ride alongside the angle pipeline
  always_ff @(posedge clk_i) begin
    if (pipe.adv) begin
      xd_q[1] <= stick_x_i;
      yd_q[1] <= stick_y_i;
      for (int k = 2; k <= SC_LAT; k++) begin
        xd_q[k] <= xd_q[k-1];
        yd_q[k] <= yd_q[k-1];
      end
    end
  end

  always_comb begin
    sx_d = 49'(xd_q[SC_LAT]) * 49'(sc_cos) - 49'(yd_q[SC_LAT]) * 49'(sc_sin);
    sy_d = 49'(xd_q[SC_LAT]) * 49'(sc_sin) + 49'(yd_q[SC_LAT]) * 49'(sc_cos);
    sq_d = 33'(xd_q[SC_LAT]) * 33'(xd_q[SC_LAT]) + 33'(yd_q[SC_LAT]) * 33'(yd_q[SC_LAT]);

    dz_sq    = 30'(dead_zone_q) * 30'(dead_zone_q);
    r13_d.dx = round_sat(sx_q);
    r13_d.dy = round_sat(sy_q);
    r13_d.sp = (sq_q > 32'(dz_sq)) ? spin_moving_q : spin_idle_q;

    res.dx = dz_keep(r13_q.dx, dead_zone_q);
    res.dy = dz_keep(r13_q.dy, dead_zone_q);
    res.sp = dz_keep(r13_q.sp, dead_zone_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q <= 1'b0;
      v13_q <= 1'b0;
    end else if (pipe.adv) begin
      v12_q <= sc_vld;
      v13_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.adv) begin
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      sq_q  <= sq_d[31:0];
      r13_q <= r13_d;
    end
  end

  // Output register with one skid entry behind it
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (v13_q) begin
      if (out_valid_q && out_stall_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (v13_q) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_x_o   = out_q.dx;
  assign drive_y_o   = out_q.dy;
  assign spin_rate_o = out_q.sp;

`ifndef NO_ASSERTIONS
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a valid output");

  a_skid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid entry lost while downstream stalled");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !skid_valid_q && !v13_q) |=> !out_valid_q)
    else $error("output valid without a transaction behind it");
`endif

endmodule
